@@ hdl/ccr_pkg.sv @@
package ccr_pkg;

  // Fraction bits of the point format; the knot step is sqrt(distance << FRAC_BITS).
  localparam int FRAC_BITS = 16;

  // Coordinate width at the ports, and the width of a stored spline point
  // (a reflected point 2*a-b of two 32-bit values needs 34 bits).
  localparam int CW = 32;
  localparam int PW = 34;

  // Width of the samples-per-segment register.
  localparam int NW = 5;
  localparam logic [NW-1:0] SPP_RESET = 5'd31;

  // Distance floor: 1e-4 in the point format, at least one LSB.
  localparam logic [63:0] MIN_LEN_RAW = ((64'd1 << FRAC_BITS) + 64'd5000) / 64'd10000;
  localparam logic [63:0] MIN_LEN = (MIN_LEN_RAW == 64'd0) ? 64'd1 : MIN_LEN_RAW;

  typedef logic [PW-1:0] crd_t;

  // One unit of work for the back end: a segment (four points) or a single point.
  typedef struct packed {
    logic               is_point;
    logic               last;
    crd_t [3:0][2:0]    pt;
  } job_t;

  // Request to the multiply-divide unit: res = x * (+/-nm) / den, toward zero.
  typedef struct packed {
    logic        start;
    logic [63:0] x;
    logic [31:0] nm;
    logic        nneg;
    logic [31:0] den;
  } mdreq_t;

endpackage

@@ hdl/ccr_scale.sv @@
module ccr_scale (
  input  logic             clk,
  input  logic             rst_n,
  input  ccr_pkg::mdreq_t  req,
  output logic             done,
  output logic [63:0]      res
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MLO  = 3'd1;
  localparam logic [2:0] ST_MHI  = 3'd2;
  localparam logic [2:0] ST_SUM  = 3'd3;
  localparam logic [2:0] ST_DIV  = 3'd4;
  localparam logic [2:0] ST_FIN  = 3'd5;
  localparam logic [6:0] DIV_LAST = 7'd95;

  logic [2:0]  st_r, st_nxt;
  logic [63:0] m_r;
  logic [31:0] nm_r;
  logic [31:0] d_r;
  logic        neg_r;
  logic [63:0] plo_r;
  logic [63:0] phi_r;
  logic [95:0] dvd_r;
  logic [31:0] rem_r;
  logic [6:0]  cnt_r;

  logic [63:0] x_mag;
  logic [31:0] mul_a;
  logic [63:0] prod;
  logic [32:0] t;
  logic [32:0] tsub;
  logic        ge;

  assign x_mag = req.x[63] ? (64'd0 - req.x) : req.x;
  assign mul_a = (st_r == ST_MLO) ? m_r[31:0] : m_r[63:32];
  assign prod  = mul_a * nm_r;

  // Restoring division, one quotient bit per cycle over the 96-bit product.
  assign t    = {rem_r, dvd_r[95]};
  assign tsub = t - {1'b0, d_r};
  assign ge   = (t >= {1'b0, d_r});

  assign done = (st_r == ST_FIN);
  assign res  = neg_r ? (64'd0 - dvd_r[63:0]) : dvd_r[63:0];

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: if (req.start) st_nxt = ST_MLO;
      ST_MLO:  st_nxt = ST_MHI;
      ST_MHI:  st_nxt = ST_SUM;
      ST_SUM:  st_nxt = ST_DIV;
      ST_DIV:  if (cnt_r == 7'd0) st_nxt = ST_FIN;
      ST_FIN:  st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unique case (st_r)
      ST_IDLE: begin
        m_r   <= x_mag;
        nm_r  <= req.nm;
        d_r   <= req.den;
        neg_r <= req.x[63] ^ req.nneg;
      end
      ST_MLO: plo_r <= prod;
      ST_MHI: phi_r <= prod;
      ST_SUM: begin
        dvd_r <= {phi_r, 32'd0} + {32'd0, plo_r};
        rem_r <= 32'd0;
        cnt_r <= DIV_LAST;
      end
      ST_DIV: begin
        rem_r <= ge ? tsub[31:0] : t[31:0];
        dvd_r <= {dvd_r[94:0], ge};
        cnt_r <= cnt_r - 7'd1;
      end
      default: begin
      end
    endcase
  end

endmodule

@@ hdl/ccr_isqrt.sv @@
module ccr_isqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] x,
  output logic        done,
  output logic [31:0] res
);

  logic        busy_r;
  logic        algn_r;
  logic [63:0] x_r;
  logic [63:0] res_r;
  logic [63:0] bit_r;
  logic [63:0] trial;

  assign trial = res_r + bit_r;
  assign done  = busy_r && (bit_r == 64'd0);
  assign res   = res_r[31:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (!busy_r) begin
      busy_r <= start;
    end else if (bit_r == 64'd0) begin
      busy_r <= 1'b0;
    end
  end

  // Digit-by-digit root, two radicand bits per cycle after the start bit is aligned.
  always_ff @(posedge clk) begin
    if (!busy_r) begin
      x_r    <= x;
      res_r  <= 64'd0;
      bit_r  <= 64'd1 << 62;
      algn_r <= 1'b1;
    end else if (bit_r != 64'd0) begin
      if (algn_r && (bit_r > x_r)) begin
        bit_r <= bit_r >> 2;
      end else begin
        algn_r <= 1'b0;
        if (x_r >= trial) begin
          x_r   <= x_r - trial;
          res_r <= (res_r >> 1) + bit_r;
        end else begin
          res_r <= res_r >> 1;
        end
        bit_r <= bit_r >> 2;
      end
    end
  end

endmodule

@@ hdl/ccr_front.sv @@
module ccr_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_push,
  input  logic signed [31:0]     in_point_x,
  input  logic signed [31:0]     in_point_y,
  input  logic signed [31:0]     in_point_z,
  input  logic                   in_final_point,
  output logic                   in_full,
  output ccr_pkg::job_t          job_o,
  output logic                   job_valid,
  input  logic                   job_pop
);

  localparam int QD = 2;

  logic [2:0][2:0][31:0] win_r;
  logic [2:0][31:0]      np_r;
  logic                  fin_r;
  logic [1:0]            seen_r;
  logic                  pend_r;
  logic [2:0]            todo_r;

  ccr_pkg::job_t q_r [QD];
  logic          wp_r;
  logic          rp_r;
  logic [1:0]    qcnt_r;

  ccr_pkg::job_t job_a;
  ccr_pkg::job_t job_b;
  ccr_pkg::job_t job_p;
  ccr_pkg::job_t job_sel;
  logic          push;
  logic          finish;
  logic          accept;
  logic [2:0]    todo_clr;

  function automatic ccr_pkg::crd_t sx(input logic [31:0] v);
    return {{(ccr_pkg::PW - 32){v[31]}}, v};
  endfunction

  function automatic ccr_pkg::crd_t refl(input logic [31:0] a, input logic [31:0] b);
    return (sx(a) << 1) - sx(b);
  endfunction

  assign in_full   = pend_r;
  assign accept    = in_push && !pend_r;
  assign job_valid = (qcnt_r != 2'd0);
  assign job_o     = q_r[rp_r];
  assign push      = pend_r && (todo_r != 3'd0) && (qcnt_r != 2'(QD));
  assign finish    = pend_r && (todo_r == 3'd0);

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      job_a.pt[0][c] = (seen_r == 2'd2) ? refl(win_r[1][c], win_r[2][c]) : sx(win_r[0][c]);
      job_a.pt[1][c] = sx(win_r[1][c]);
      job_a.pt[2][c] = sx(win_r[2][c]);
      job_a.pt[3][c] = sx(np_r[c]);
      job_b.pt[0][c] = (seen_r == 2'd1) ? refl(win_r[2][c], np_r[c]) : sx(win_r[1][c]);
      job_b.pt[1][c] = sx(win_r[2][c]);
      job_b.pt[2][c] = sx(np_r[c]);
      job_b.pt[3][c] = refl(np_r[c], win_r[2][c]);
      for (int i = 0; i < 4; i++) begin
        job_p.pt[i][c] = sx(np_r[c]);
      end
    end
    job_a.is_point = 1'b0;
    job_a.last     = !fin_r;
    job_b.is_point = 1'b0;
    job_b.last     = 1'b0;
    job_p.is_point = 1'b1;
    job_p.last     = 1'b1;
  end

  always_comb begin
    priority if (todo_r[0]) begin
      job_sel  = job_a;
      todo_clr = 3'b001;
    end else if (todo_r[1]) begin
      job_sel  = job_b;
      todo_clr = 3'b010;
    end else begin
      job_sel  = job_p;
      todo_clr = 3'b100;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
      seen_r <= 2'd0;
      todo_r <= 3'd0;
    end else if (accept) begin
      pend_r <= 1'b1;
      todo_r <= {in_final_point, in_final_point && (seen_r != 2'd0), seen_r[1]};
    end else if (push) begin
      todo_r <= todo_r & ~todo_clr;
    end else if (finish) begin
      pend_r <= 1'b0;
      seen_r <= fin_r ? 2'd0 : ((seen_r == 2'd3) ? 2'd3 : seen_r + 2'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      np_r  <= {in_point_z, in_point_y, in_point_x};
      fin_r <= in_final_point;
    end
    if (finish) begin
      win_r <= {np_r, win_r[2], win_r[1]};
    end
    if (push) begin
      q_r[wp_r] <= job_sel;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= 1'b0;
      rp_r   <= 1'b0;
      qcnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (job_pop) rp_r <= !rp_r;
      qcnt_r <= qcnt_r + {1'b0, push} - {1'b0, job_pop};
    end
  end

endmodule

@@ hdl/ccr_back.sv @@
module ccr_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  ccr_pkg::job_t               job_i,
  input  logic                        job_valid,
  output logic                        job_pop,
  input  logic [ccr_pkg::NW-1:0]      spp,
  output logic                        out_valid,
  output logic [31:0]                 out_x,
  output logic [31:0]                 out_y,
  output logic [31:0]                 out_z,
  output logic                        out_end,
  input  logic                        out_pop
);

  localparam logic [3:0] B_IDLE  = 4'd0;
  localparam logic [3:0] B_KSQ   = 4'd1;
  localparam logic [3:0] B_KSQW  = 4'd2;
  localparam logic [3:0] B_KR1   = 4'd3;
  localparam logic [3:0] B_KR1W  = 4'd4;
  localparam logic [3:0] B_KR2   = 4'd5;
  localparam logic [3:0] B_KR2W  = 4'd6;
  localparam logic [3:0] B_SEG   = 4'd7;
  localparam logic [3:0] B_UST   = 4'd8;
  localparam logic [3:0] B_UW    = 4'd9;
  localparam logic [3:0] B_TT    = 4'd10;
  localparam logic [3:0] B_OP    = 4'd11;
  localparam logic [3:0] B_OPW   = 4'd12;
  localparam logic [3:0] B_EMIT  = 4'd13;
  localparam logic [3:0] B_PTOUT = 4'd14;

  localparam int NW = ccr_pkg::NW;

  logic [3:0]    st_r, st_nxt;
  logic [63:0]   pt_r [4][3];
  logic          last_r;
  logic [NW-1:0] n_r;
  logic [NW-1:0] k_r;
  logic [1:0]    kp_r;
  logic [1:0]    c_r;
  logic [2:0]    j_r;
  logic [63:0]   sum_r;
  logic [31:0]   kn_r [3];
  logic [31:0]   u_r, tt_r, t2_r, k1223_r;
  logic [63:0]   a1_r, a2_r, a3_r, b1_r, b2_r;
  logic [63:0]   r_r [3];
  logic          ov_r;
  logic [31:0]   ox_r, oy_r, oz_r;
  logic          oend_r;

  ccr_pkg::mdreq_t req;
  logic            sc_done;
  logic [63:0]     sc_res;
  logic            sq_start;
  logic [63:0]     sq_x;
  logic            sq_done;
  logic [31:0]     sq_res;

  logic [63:0] pa [3];
  logic [63:0] pb [3];
  logic [63:0] dif [3];
  logic [63:0] dmag [3];
  logic [63:0] dsh [3];
  logic [2:0]  s;
  logic [30:0] vsel;
  logic [63:0] len_raw;
  logic [63:0] len;
  logic [63:0] op_x, op_base, op_sum;
  logic [31:0] op_nm, op_den;
  logic        op_nneg;
  logic        k_last;

  function automatic logic [31:0] sat32(input logic [63:0] v);
    logic [31:0] r;
    if (!v[63] && (|v[62:31])) r = 32'h7FFF_FFFF;
    else if (v[63] && !(&v[62:31])) r = 32'h8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  ccr_scale u_scale (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .done  (sc_done),
    .res   (sc_res)
  );

  ccr_isqrt u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start),
    .x     (sq_x),
    .done  (sq_done),
    .res   (sq_res)
  );

  // Distance terms of the knot pair under work.
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      unique case (kp_r)
        2'd0: begin
          pa[c] = pt_r[0][c];
          pb[c] = pt_r[1][c];
        end
        2'd1: begin
          pa[c] = pt_r[1][c];
          pb[c] = pt_r[2][c];
        end
        default: begin
          pa[c] = pt_r[2][c];
          pb[c] = pt_r[3][c];
        end
      endcase
      dif[c]  = pb[c] - pa[c];
      dmag[c] = dif[c][63] ? (64'd0 - dif[c]) : dif[c];
    end
    // Smallest shift that brings every term below 2^31.
    s = 3'd4;
    for (int i = 4; i >= 0; i--) begin
      if (((dmag[0] >> i) < 64'h8000_0000) && ((dmag[1] >> i) < 64'h8000_0000) &&
          ((dmag[2] >> i) < 64'h8000_0000)) begin
        s = 3'(i);
      end
    end
    for (int c = 0; c < 3; c++) begin
      dsh[c] = dmag[c] >> s;
    end
    unique case (c_r)
      2'd0:    vsel = dsh[0][30:0];
      2'd1:    vsel = dsh[1][30:0];
      default: vsel = dsh[2][30:0];
    endcase
  end

  assign len_raw = {32'd0, sq_res} << s;
  assign len     = (len_raw < ccr_pkg::MIN_LEN) ? ccr_pkg::MIN_LEN : len_raw;

  // Pyramid step operands; the coordinate under work always sits at index 0.
  always_comb begin
    op_nneg = 1'b0;
    unique case (j_r)
      3'd0: begin
        op_x = pt_r[1][0] - pt_r[0][0]; op_nm = tt_r; op_den = kn_r[0]; op_base = pt_r[0][0];
      end
      3'd1: begin
        op_x = pt_r[2][0] - pt_r[1][0]; op_nm = u_r; op_den = kn_r[1]; op_base = pt_r[1][0];
      end
      3'd2: begin
        op_x = pt_r[3][0] - pt_r[2][0]; op_nm = kn_r[1] - u_r; op_nneg = 1'b1;
        op_den = kn_r[2]; op_base = pt_r[2][0];
      end
      3'd3: begin
        op_x = a2_r - a1_r; op_nm = tt_r; op_den = t2_r; op_base = a1_r;
      end
      3'd4: begin
        op_x = a3_r - a2_r; op_nm = u_r; op_den = k1223_r; op_base = a2_r;
      end
      default: begin
        op_x = b2_r - b1_r; op_nm = u_r; op_den = kn_r[1]; op_base = b1_r;
      end
    endcase
  end

  assign op_sum = op_base + sc_res;

  always_comb begin
    req = '0;
    unique case (st_r)
      B_KSQ: begin
        req.start = 1'b1;
        req.x     = {33'd0, vsel};
        req.nm    = {1'b0, vsel};
        req.den   = 32'd1;
      end
      B_UST: begin
        req.start = 1'b1;
        req.x     = {32'd0, kn_r[1]};
        req.nm    = {{(32 - NW){1'b0}}, k_r};
        req.den   = {{(32 - NW){1'b0}}, n_r};
      end
      B_OP: begin
        req.start = 1'b1;
        req.x     = op_x;
        req.nm    = op_nm;
        req.nneg  = op_nneg;
        req.den   = op_den;
      end
      default: req = '0;
    endcase
  end

  assign sq_start = (st_r == B_KR1) || (st_r == B_KR2);
  assign sq_x     = (st_r == B_KR1) ? sum_r : (sum_r << ccr_pkg::FRAC_BITS);
  assign k_last   = (k_r == (n_r - NW'(1)));
  assign job_pop  = (st_r == B_IDLE) && job_valid;

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      B_IDLE:  if (job_valid) st_nxt = job_i.is_point ? B_PTOUT : B_KSQ;
      B_KSQ:   st_nxt = B_KSQW;
      B_KSQW:  if (sc_done) st_nxt = (c_r == 2'd2) ? B_KR1 : B_KSQ;
      B_KR1:   st_nxt = B_KR1W;
      B_KR1W:  if (sq_done) st_nxt = B_KR2;
      B_KR2:   st_nxt = B_KR2W;
      B_KR2W:  if (sq_done) st_nxt = (kp_r == 2'd2) ? B_SEG : B_KSQ;
      B_SEG:   st_nxt = (n_r == '0) ? B_IDLE : B_UST;
      B_UST:   st_nxt = B_UW;
      B_UW:    if (sc_done) st_nxt = B_TT;
      B_TT:    st_nxt = B_OP;
      B_OP:    st_nxt = B_OPW;
      B_OPW:   if (sc_done) st_nxt = ((j_r == 3'd5) && (c_r == 2'd2)) ? B_EMIT : B_OP;
      B_EMIT:  if (!ov_r) st_nxt = k_last ? B_IDLE : B_UST;
      B_PTOUT: if (!ov_r) st_nxt = B_IDLE;
      default: st_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= B_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unique case (st_r)
      B_IDLE: begin
        for (int i = 0; i < 4; i++) begin
          for (int c = 0; c < 3; c++) begin
            pt_r[i][c] <= {{(64 - ccr_pkg::PW){job_i.pt[i][c][ccr_pkg::PW-1]}}, job_i.pt[i][c]};
          end
        end
        last_r <= job_i.last;
        n_r    <= spp;
        kp_r   <= 2'd0;
        c_r    <= 2'd0;
        sum_r  <= 64'd0;
      end
      B_KSQW: begin
        if (sc_done) begin
          sum_r <= sum_r + sc_res;
          c_r   <= (c_r == 2'd2) ? 2'd0 : c_r + 2'd1;
        end
      end
      B_KR1W: if (sq_done) sum_r <= len;
      B_KR2W: begin
        if (sq_done) begin
          kn_r[kp_r] <= sq_res;
          kp_r       <= kp_r + 2'd1;
          sum_r      <= 64'd0;
        end
      end
      B_SEG: begin
        t2_r    <= kn_r[0] + kn_r[1];
        k1223_r <= kn_r[1] + kn_r[2];
        k_r     <= '0;
      end
      B_UW: if (sc_done) u_r <= sc_res[31:0];
      B_TT: begin
        tt_r <= kn_r[0] + u_r;
        j_r  <= 3'd0;
        c_r  <= 2'd0;
      end
      B_OPW: begin
        if (sc_done) begin
          unique case (j_r)
            3'd0: a1_r <= op_sum;
            3'd1: a2_r <= op_sum;
            3'd2: a3_r <= op_sum;
            3'd3: b1_r <= op_sum;
            3'd4: b2_r <= op_sum;
            default: begin
              r_r[0] <= r_r[1];
              r_r[1] <= r_r[2];
              r_r[2] <= op_sum;
              for (int i = 0; i < 4; i++) begin
                pt_r[i][0] <= pt_r[i][1];
                pt_r[i][1] <= pt_r[i][2];
                pt_r[i][2] <= pt_r[i][0];
              end
              c_r <= c_r + 2'd1;
            end
          endcase
          j_r <= (j_r == 3'd5) ? 3'd0 : j_r + 3'd1;
        end
      end
      B_EMIT: if (!ov_r) k_r <= k_r + NW'(1);
      default: begin
      end
    endcase
  end

  // Result register: holds one sample until it is popped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (((st_r == B_EMIT) || (st_r == B_PTOUT)) && !ov_r) begin
      ov_r <= 1'b1;
    end else if (out_pop) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((st_r == B_EMIT) && !ov_r) begin
      ox_r   <= sat32(r_r[0]);
      oy_r   <= sat32(r_r[1]);
      oz_r   <= sat32(r_r[2]);
      oend_r <= last_r && k_last;
    end else if ((st_r == B_PTOUT) && !ov_r) begin
      ox_r   <= sat32(pt_r[0][0]);
      oy_r   <= sat32(pt_r[0][1]);
      oz_r   <= sat32(pt_r[0][2]);
      oend_r <= 1'b1;
    end
  end

  assign out_valid = ov_r;
  assign out_x     = ox_r;
  assign out_y     = oy_r;
  assign out_z     = oz_r;
  assign out_end   = oend_r;

endmodule

@@ hdl/centripetal_catmull_rom_sampler.sv @@
// The sample rate is set by the one shared multiply-divide unit, which works on one
// scaled term at a time, 19 terms per sample.
// Reset: synchronous, active low; clears the point count, queues and result register and
// sets samples_per_segment to 31. The point window is not cleared.
module centripetal_catmull_rom_sampler (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_push,
  output logic                       in_full,
  input  logic signed [31:0]         in_point_x,
  input  logic signed [31:0]         in_point_y,
  input  logic signed [31:0]         in_point_z,
  input  logic                       in_final_point,
  output logic                       out_empty,
  input  logic                       out_pop,
  output logic signed [31:0]         out_curve_x,
  output logic signed [31:0]         out_curve_y,
  output logic signed [31:0]         out_curve_z,
  output logic                       out_run_end,
  input  logic                       cfg_write,
  input  logic [ccr_pkg::NW-1:0]     cfg_samples_per_segment
);

  // The front end keeps the last three points and turns each input beat into up to
  // three jobs: the segment it completes, the closing segment on a final point, and
  // the final point itself. A two-entry job queue decouples it from the back end,
  // which computes three knot steps per segment and then evaluates the pyramid of
  // lerps per sample, one scaled term at a time.

  logic [ccr_pkg::NW-1:0] spp_r;
  ccr_pkg::job_t          job;
  logic                   job_valid;
  logic                   job_pop;
  logic                   out_valid;
  logic [31:0]            cx, cy, cz;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spp_r <= ccr_pkg::SPP_RESET;
    end else if (cfg_write) begin
      spp_r <= cfg_samples_per_segment;
    end
  end

  ccr_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_point_x     (in_point_x),
    .in_point_y     (in_point_y),
    .in_point_z     (in_point_z),
    .in_final_point (in_final_point),
    .in_full        (in_full),
    .job_o          (job),
    .job_valid      (job_valid),
    .job_pop        (job_pop)
  );

  ccr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_i     (job),
    .job_valid (job_valid),
    .job_pop   (job_pop),
    .spp       (spp_r),
    .out_valid (out_valid),
    .out_x     (cx),
    .out_y     (cy),
    .out_z     (cz),
    .out_end   (out_run_end),
    .out_pop   (out_pop)
  );

  assign out_empty   = !out_valid;
  assign out_curve_x = cx;
  assign out_curve_y = cy;
  assign out_curve_z = cz;

  // The back end only takes a job that the queue actually holds.
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    job_pop |-> job_valid)
    else $error("job taken from an empty queue");

  // An accepted beat blocks further input until all of its jobs are queued.
  a_accept_full: assert property (@(posedge clk) disable iff (!rst_n)
    (in_push && !in_full) |=> in_full)
    else $error("input not held off after an accepted beat");

endmodule
